// File: hdl/sasg_pkg.sv
`default_nettype none
package sasg_pkg;
    localparam int unsigned WIDE_W = 145;   // divisor shifted by 33 reaches 2^145
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 48;
    localparam int unsigned IN_DATA_W = 64;
    localparam int unsigned OUT_DATA_W = 40;

    typedef logic [WIDE_W-1:0] t_wide;

    // request kinds
    localparam logic [1:0] REQ_POLL = 2'd0;
    localparam logic [1:0] REQ_REL  = 2'd1;
    localparam logic [1:0] REQ_ABS  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FASTEST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOWEST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP    = 3'd4;

    // run direction codes
    localparam logic [1:0] RUN_STOP = 2'b00;
    localparam logic [1:0] RUN_POS  = 2'b01;
    localparam logic [1:0] RUN_NEG  = 2'b11;
endpackage
`default_nettype wire

// File: hdl/stepper_accel_step_generator_top.sv
`default_nettype none
// Stepper step generator with a trapezoidal speed ramp. Each input item is a
// timer poll (tuser 0) or a relative (1) or absolute (2) move; every item gives
// exactly one result item. Moves are taken only while the motor is stopped.
// Periods are unsigned Q20.12 microseconds, coefficients are scaled by 2^64.
// Timing: a move, a poll that issues no step, or an unused kind gives its
// result in the cycle after it is accepted. A poll that issues a step runs the
// period planner, which drives one shared 145-bit adder/subtractor through a
// shift-add multiplier and a restoring divider: it squares the period, scales
// the square by the brake coefficient, divides for the brake distance, cubes
// the period, scales the cube by the ramp coefficient and finishes; the
// division is skipped when the brake divisor is zero. The input is not ready
// while an item is being worked on or its result waits to be taken.
module stepper_accel_step_generator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // time_now[31:0], move_amount[63:32]
    input  wire logic [sasg_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // step_pulse[0], dir_level[1], moving[2], position[34:3], cmd_accepted[35], zero fill
    output logic [sasg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [sasg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sasg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sasg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_DEN  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_CUBE = 3'd4;
    localparam logic [2:0] S_X    = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // configuration
    logic [31:0] r_fastest, r_slowest, r_stop;
    logic [47:0] r_accel, r_decel;

    // motion state
    logic [1:0]  r_run;
    logic        r_dir;
    logic [31:0] r_pos, r_target, r_cur, r_next, r_last;

    // sequencer and datapath
    logic [2:0]  r_state;
    logic [5:0]  r_cnt;
    t_wide       r_acc, r_opa;
    logic [47:0] r_mb;
    logic [63:0] r_sq;
    logic [32:0] r_q;
    logic [31:0] r_brake, r_delta;
    logic        r_up, r_down;
    logic        r_pulse, r_cmd;

    // shared adder: add for multiply steps, subtract for divide steps
    logic        sub;
    t_wide       addend;
    logic [WIDE_W:0] sum;
    t_wide       n_acc;
    logic        last;

    assign sub    = (r_state == S_DIV);
    assign addend = sub ? ~r_opa : r_opa;
    assign sum    = {1'b0, r_acc} + {1'b0, addend} + {{WIDE_W{1'b0}}, sub};
    assign last   = (r_cnt == 6'd1);

    always_comb begin
        n_acc = r_acc;
        if (sub) begin
            if (sum[WIDE_W]) n_acc = sum[WIDE_W-1:0];   // carry out means no borrow
        end else if (r_mb[0]) begin
            n_acc = sum[WIDE_W-1:0];
        end
    end

    // ramp decision from position and brake distance
    logic [31:0] diff, mag;
    logic        ahead, toward, dec_down, dec_up;
    assign diff   = r_target - r_pos;
    assign ahead  = ~diff[31];
    assign mag    = ahead ? diff : (32'd0 - diff);
    assign toward = (r_run == RUN_POS && ahead) || (r_run == RUN_NEG && !ahead);
    always_comb begin
        dec_down = 1'b0;
        dec_up   = 1'b0;
        if (toward) begin
            if (mag < r_brake || r_next < r_fastest) dec_down = 1'b1;
            else dec_up = 1'b1;
        end else if (r_cur < r_slowest) begin
            dec_down = 1'b1;
        end
    end

    // next period from the ramp delta
    logic [31:0] np;
    logic [32:0] slow_sum;
    always_comb begin
        slow_sum = {1'b0, r_cur} + {1'b0, r_delta};
        np = r_next;
        if (r_up) begin
            if (r_delta >= r_cur || (r_cur - r_delta) < r_fastest) np = r_fastest;
            else np = r_cur - r_delta;
        end else if (r_down) begin
            np = slow_sum[32] ? 32'hFFFF_FFFF : slow_sum[31:0];
            if (np > r_slowest) np = r_slowest;
        end
    end

    logic [1:0]  req;
    logic [31:0] now, amt;
    logic        in_acc;
    logic [32:0] q_fin;
    assign req    = s_axis_tuser;
    assign now    = s_axis_tdata[31:0];
    assign amt    = s_axis_tdata[63:32];
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign q_fin  = {r_q[31:0], sum[WIDE_W]};

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {4'd0, r_cmd, r_pos, (r_run != RUN_STOP), r_dir, r_pulse};
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fastest <= 32'd4096000;
            r_accel   <= 48'd18446744;
            r_decel   <= 48'd18446744;
            r_slowest <= 32'd129511015;
            r_stop    <= 32'd46253934;
            r_run     <= RUN_STOP;
            r_dir     <= 1'b0;
            r_pos     <= '0;
            r_target  <= '0;
            r_cur     <= '0;
            r_next    <= '0;
            r_last    <= '0;
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_pulse   <= 1'b0;
            r_cmd     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_FASTEST: r_fastest <= i_cfg_data[31:0];
                    CFG_ACCEL:   r_accel   <= i_cfg_data;
                    CFG_DECEL:   r_decel   <= i_cfg_data;
                    CFG_SLOWEST: r_slowest <= i_cfg_data[31:0];
                    CFG_STOP:    r_stop    <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pulse <= 1'b0;
                        r_cmd   <= 1'b0;
                        r_state <= S_OUT;
                        if (req == REQ_POLL) begin
                            if (r_run == RUN_STOP) begin
                                if (diff != 32'd0) begin
                                    r_run  <= ahead ? RUN_POS : RUN_NEG;
                                    r_dir  <= ahead;
                                    r_next <= r_slowest;
                                    r_last <= now;
                                end
                            end else if ((now - r_last) >= {12'd0, r_next[31:12]}) begin
                                r_pulse <= 1'b1;
                                r_pos   <= r_pos + ((r_run == RUN_POS) ? 32'd1 : 32'hFFFF_FFFF);
                                r_cur   <= r_next;
                                r_last  <= now;
                                r_acc   <= '0;
                                r_opa   <= {{(WIDE_W-32){1'b0}}, r_next};
                                r_mb    <= {16'd0, r_next};
                                r_cnt   <= 6'd32;
                                r_state <= S_SQ;
                            end
                        end else if (req == REQ_REL || req == REQ_ABS) begin
                            if (r_run == RUN_STOP) begin
                                r_target <= (req == REQ_REL) ? (r_pos + amt) : amt;
                                r_cmd    <= 1'b1;
                            end
                        end
                    end
                end
                S_SQ: begin
                    r_acc <= n_acc;
                    r_opa <= r_opa << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt - 6'd1;
                    if (last) begin
                        r_sq    <= n_acc[63:0];
                        r_acc   <= '0;
                        r_opa   <= {{(WIDE_W-64){1'b0}}, n_acc[63:0]};
                        r_mb    <= r_decel;
                        r_cnt   <= 6'd48;
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    r_acc <= n_acc;
                    r_opa <= r_opa << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt - 6'd1;
                    if (last) begin
                        if (n_acc[111:0] == 112'd0) begin
                            // zero divisor: brake distance saturates
                            r_brake <= 32'hFFFF_FFFF;
                            r_acc   <= '0;
                            r_opa   <= {{(WIDE_W-64){1'b0}}, r_sq};
                            r_mb    <= {16'd0, r_cur};
                            r_cnt   <= 6'd32;
                            r_state <= S_CUBE;
                        end else begin
                            r_acc   <= {{(WIDE_W-112){1'b0}}, n_acc[111:0]}
                                       + {{(WIDE_W-89){1'b0}}, 1'b1, 88'd0};
                            r_opa   <= {n_acc[111:0], 33'd0};
                            r_q     <= '0;
                            r_cnt   <= 6'd33;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_acc <= n_acc;
                    r_opa <= r_opa >> 1;
                    r_q   <= q_fin;
                    r_cnt <= r_cnt - 6'd1;
                    if (last) begin
                        r_brake <= q_fin[32] ? 32'hFFFF_FFFF : q_fin[31:0];
                        r_acc   <= '0;
                        r_opa   <= {{(WIDE_W-64){1'b0}}, r_sq};
                        r_mb    <= {16'd0, r_cur};
                        r_cnt   <= 6'd32;
                        r_state <= S_CUBE;
                    end
                end
                S_CUBE: begin
                    r_acc <= n_acc;
                    r_opa <= r_opa << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt - 6'd1;
                    if (last) begin
                        r_up    <= dec_up;
                        r_down  <= dec_down;
                        r_acc   <= '0;
                        r_opa   <= {{(WIDE_W-96){1'b0}}, n_acc[95:0]};
                        r_mb    <= dec_up ? r_accel : r_decel;
                        r_cnt   <= 6'd48;
                        r_state <= S_X;
                    end
                end
                S_X: begin
                    r_acc <= n_acc;
                    r_opa <= r_opa << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt - 6'd1;
                    if (last) begin
                        r_delta <= (n_acc[143:120] != 24'd0) ? 32'hFFFF_FFFF
                                                              : n_acc[119:88];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_OUT;
                    if (r_pos == r_target && np >= r_stop) begin
                        r_cur  <= '0;
                        r_next <= '0;
                        r_run  <= RUN_STOP;
                    end else begin
                        r_next <= np;
                        // moving away at slowest speed: turn around
                        if (!toward && !r_down) begin
                            r_run <= ahead ? RUN_POS : RUN_NEG;
                            r_dir <= ahead;
                        end
                    end
                    if (r_pos == r_target && np >= r_stop && !toward && !r_down) begin
                        r_dir <= ahead;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");
    a_pulse_not_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_pulse && r_cmd))
        else $error("step and command flags both set");
    a_stopped_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run == RUN_STOP) |-> (r_cur == 32'd0))
        else $error("period left nonzero while stopped");
    a_run_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run != 2'b10)
        else $error("bad run direction");
endmodule
`default_nettype wire

// File: tb/tb_stepper_accel_step_generator_top.sv
`default_nettype none
module tb_stepper_accel_step_generator_top;
    import sasg_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // time_now[31:0], move_amount[63:32]
    logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // step_pulse[0], dir_level[1], moving[2], position[34:3], cmd_accepted[35]
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    stepper_accel_step_generator_top dut (.*);

    always #4 i_clk = ~i_clk;

    typedef struct packed {
        logic        cmd_accepted;
        logic [31:0] position;
        logic        moving;
        logic        dir_level;
        logic        step_pulse;
    } t_status;

    // predictor copy of configuration and motion state
    logic [31:0] m_fastest, m_slowest, m_stop;
    logic [47:0] m_accel, m_decel;
    logic [1:0]  m_run;
    logic        m_dir;
    logic [31:0] m_pos, m_target, m_cur_per, m_next_per, m_last_time;
    logic [31:0] now_us;

    t_status status_q[$];
    int unsigned n_errors = 0;
    int unsigned n_sent = 0;
    longint unsigned cycle_cnt = 0;
    bit stall_en = 1'b1;

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_cnt);
        n_errors++;
    endtask

    // floor(coef * p^3 / 2^88), saturated
    function automatic logic [31:0] ramp_delta(input logic [31:0] p, input logic [47:0] coef);
        logic [159:0] prod;
        logic [159:0] sh;
        prod = 160'(p) * 160'(p) * 160'(p) * 160'(coef);
        sh = prod >> 88;
        return (sh > 160'hFFFF_FFFF) ? 32'hFFFF_FFFF : sh[31:0];
    endfunction

    // round-half-up of 2^87 / (decel * p^2), saturated
    function automatic logic [31:0] brake_dist(input logic [31:0] p);
        logic [159:0] den, num, q;
        den = 160'(p) * 160'(p) * 160'(m_decel);
        if (den == 0) return 32'hFFFF_FFFF;
        num = (160'd1 << 88) + den;
        q = num / (den << 1);
        return (q > 160'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    task automatic plan_period();
        logic [31:0] diff, mag, dd, d;
        logic ahead, toward, up, down;
        logic [32:0] n;
        diff = m_target - m_pos;
        ahead = ~diff[31];
        mag = ahead ? diff : -diff;
        dd = brake_dist(m_cur_per);
        up = 0; down = 0;
        toward = (m_run == RUN_POS && ahead) || (m_run == RUN_NEG && !ahead);
        if (m_run == RUN_STOP) return;
        if (toward) begin
            if (mag < dd || m_next_per < m_fastest) down = 1;
            else up = 1;
        end else if (m_cur_per < m_slowest) begin
            down = 1;
        end else begin
            m_run = ahead ? RUN_POS : RUN_NEG;
            m_dir = ahead;
        end
        if (up) begin
            d = ramp_delta(m_cur_per, m_accel);
            if (d >= m_cur_per || m_cur_per - d < m_fastest) m_next_per = m_fastest;
            else m_next_per = m_cur_per - d;
        end
        if (down) begin
            n = 33'(m_cur_per) + 33'(ramp_delta(m_cur_per, m_decel));
            if (n > 33'hFFFF_FFFF) n = 33'hFFFF_FFFF;
            if (n > 33'(m_slowest)) n = 33'(m_slowest);
            m_next_per = n[31:0];
        end
    endtask

    task automatic predict_status(input logic [1:0] kind, input logic [31:0] t,
                                  input logic [31:0] amt);
        t_status r;
        logic [31:0] diff;
        r = '0;
        if (kind == REQ_POLL) begin
            if (m_run == RUN_STOP) begin
                diff = m_target - m_pos;
                if (diff != 0) begin
                    m_run = diff[31] ? RUN_NEG : RUN_POS;
                    m_dir = ~diff[31];
                    m_next_per = m_slowest;
                    m_last_time = t;
                end
            end else if (t - m_last_time >= (m_next_per >> 12)) begin
                r.step_pulse = 1;
                m_pos = m_pos + ((m_run == RUN_POS) ? 32'd1 : 32'hFFFF_FFFF);
                m_cur_per = m_next_per;
                m_last_time = t;
                plan_period();
                if (m_pos == m_target && m_next_per >= m_stop) begin
                    m_cur_per = 0; m_next_per = 0; m_run = RUN_STOP;
                end
            end
        end else if (kind == REQ_REL || kind == REQ_ABS) begin
            if (m_run == RUN_STOP) begin
                m_target = (kind == REQ_REL) ? m_pos + amt : amt;
                r.cmd_accepted = 1;
            end
        end
        r.dir_level = m_dir;
        r.moving = (m_run != RUN_STOP);
        r.position = m_pos;
        status_q.push_back(r);
    endtask

    // called at a falling edge; valid stays high into the next item when there is no gap
    task automatic send_item(input logic [1:0] kind, input logic [31:0] t,
                             input logic [31:0] amt);
        int gap;
        gap = stall_en ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {amt, t};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_status(kind, t, amt);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic poll();
        now_us = now_us + $urandom_range(0, 40000);
        send_item(REQ_POLL, now_us, 32'd0);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_FASTEST: m_fastest = val[31:0];
            CFG_ACCEL:   m_accel = val;
            CFG_DECEL:   m_decel = val;
            CFG_SLOWEST: m_slowest = val[31:0];
            CFG_STOP:    m_stop = val[31:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_profile(input logic [31:0] fast, input logic [47:0] acc,
                                input logic [47:0] dec, input logic [31:0] slow,
                                input logic [31:0] stp);
        wait_idle();
        write_reg(CFG_FASTEST, fast);
        write_reg(CFG_ACCEL, acc);
        write_reg(CFG_DECEL, dec);
        write_reg(CFG_SLOWEST, slow);
        write_reg(CFG_STOP, stp);
        i_cfg_valid <= 1'b0;
    endtask

    // a move then polls, with occasional random moves or unused kinds, until the motor stops again (bounded)
    task automatic run_move(input logic [1:0] kind, input logic [31:0] amt, input int max_polls);
        int k;
        send_item(kind, $urandom, amt);
        k = 0;
        poll();
        while (m_run != RUN_STOP && k < max_polls) begin
            if ($urandom_range(0, 19) == 0)
                send_item(2'($urandom_range(1, 3)), $urandom, $urandom);
            else
                poll();
            k++;
        end
    endtask

    // directed: field extremes, every kind, rejected moves, ignored kind
    task automatic test_directed();
        send_item(REQ_POLL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(2'd3, 32'hFFFF_FFFF, 32'h8000_0000);
        send_item(REQ_REL, 32'd0, 32'd3);
        send_item(REQ_ABS, 32'd0, 32'd7);           // retarget while stopped
        send_item(REQ_POLL, 32'd0, 32'd0);          // starts motion
        send_item(REQ_REL, 32'd0, 32'd100);         // rejected while running
        send_item(REQ_POLL, 32'd10, 32'd0);         // too early
        send_item(REQ_POLL, 32'hFFFF_FFF0, 32'd0);  // wrapped time, steps
        repeat (12) poll();
        send_item(2'd3, 32'd0, 32'h7FFF_FFFF);
        send_item(REQ_ABS, 32'hFFFF_FFFF, 32'h8000_0000);
        send_item(REQ_ABS, 32'd0, 32'h7FFF_FFFF);
    endtask

    // ramp through several profiles including extremes
    task automatic test_profiles();
        load_profile(32'd4096000, 48'd18446744, 48'd18446744, 32'd129511015, 32'd46253934);
        run_move(REQ_REL, 32'd20, 120);
        run_move(REQ_REL, -32'sd15, 120);
        load_profile(32'd0, 48'hFFFF_FFFF_FFFF, 48'd0, 32'hFFFF_FFFF, 32'd0);
        run_move(REQ_REL, 32'd3, 12);
        load_profile(32'hFFFF_FFFF, 48'd0, 48'hFFFF_FFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        run_move(REQ_REL, 32'd2, 12);
        load_profile(32'd409600, 48'd184467440, 48'd184467440, 32'd40960000, 32'd20480000);
    endtask

    task automatic test_random();
        while (n_sent < 700) begin
            if ($urandom_range(0, 9) == 0) stall_en = ~stall_en;
            if ($urandom_range(0, 7) == 0) begin
                send_item(2'($urandom_range(0, 3)), $urandom, $urandom);
            end else begin
                run_move($urandom_range(0, 1) ? REQ_REL : REQ_ABS,
                         $urandom_range(0, 1) ? 32'($signed($urandom_range(0, 24)) - 12)
                                              : m_pos + $urandom_range(0, 16) - 8, 40);
            end
        end
        stall_en = 1'b1;
    endtask

    // receiver draws a wait before taking each result
    initial begin : rx_side
        int wait_n;
        @(negedge i_clk);
        forever begin
            wait_n = stall_en ? $urandom_range(0, 9) : 0;
            if (wait_n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && i_rst_n)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // checks each result against the oldest prediction
    always @(posedge i_clk) begin
        t_status want;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (status_q.size() == 0) begin
                report_mismatch("unexpected item", m_axis_tdata, '0);
            end else begin
                want = status_q.pop_front();
                if (m_axis_tdata[0] !== want.step_pulse)
                    report_mismatch("step_pulse", m_axis_tdata, 40'(want));
                if (m_axis_tdata[1] !== want.dir_level)
                    report_mismatch("dir_level", m_axis_tdata, 40'(want));
                if (m_axis_tdata[2] !== want.moving)
                    report_mismatch("moving", m_axis_tdata, 40'(want));
                if (m_axis_tdata[34:3] !== want.position)
                    report_mismatch("position", m_axis_tdata, 40'(want));
                if (m_axis_tdata[35] !== want.cmd_accepted)
                    report_mismatch("cmd_accepted", m_axis_tdata, 40'(want));
            end
        end
        if (cycle_cnt > 2_000_000) begin
            $display("stepper_accel_step_generator_top regression: fail");
            $finish;
        end
    end

    initial begin
        m_fastest = 32'd4096000; m_accel = 48'd18446744; m_decel = 48'd18446744;
        m_slowest = 32'd129511015; m_stop = 32'd46253934;
        m_run = RUN_STOP; m_dir = 0; m_pos = 0; m_target = 0;
        m_cur_per = 0; m_next_per = 0; m_last_time = 0; now_us = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_profiles();
        test_random();
        wait_idle();
        if (n_errors == 0 && status_q.size() == 0) begin
            $display("stepper_accel_step_generator_top regression: pass");
        end else begin
            $display("stepper_accel_step_generator_top regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
